FILE: rtl/core/lssr_pkg.sv
// Shared types, codes and the helper function of the log stream sanitiser.
`timescale 1ns / 1ps
package lssr_pkg;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_MARK  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  localparam int unsigned RESULT_CAP = 32;
  localparam logic [7:0] CH_ESC  = 8'h1b;
  localparam logic [7:0] CH_LBR  = 8'h5b;
  localparam logic [7:0] CH_QM   = 8'h3f;
  localparam logic [7:0] CH_NL   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_DEL  = 8'h7f;
  localparam logic [7:0] CH_BSL  = 8'h5c;
  localparam logic [7:0] CH_SL   = 8'h2f;

  typedef struct packed {
    logic        kind;
    logic [2:0]  byte_count;
    logic [31:0] text_bytes;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic match_start;
    logic m_next;
    logic m_hit;
    logic k_start;
    logic k_next;
    logic decide;
    logic shift;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_drain;
    logic loop_go;
    logic m_end;
    logic m_skip;
    logic k_eq;
    logic k_last;
    logic dec_stall;
    logic skip_one;
    logic fin_need;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5a]}) r = c + 8'h20;
    else if (c == CH_BSL) r = CH_SL;
    return r;
  endfunction

endpackage

FILE: rtl/core/lssr_if.sv
// Request channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
interface lssr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] byte_value;
  logic       marker_end;
  modport source (output valid, operation, byte_value, marker_end, input ready);
  modport sink (input valid, operation, byte_value, marker_end, output ready);
endinterface

interface lssr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  byte_count;
  logic [31:0] text_bytes;
  logic        last;
  modport source (output valid, kind, byte_count, text_bytes, last, input ready);
  modport sink (input valid, kind, byte_count, text_bytes, last, output ready);
endinterface

FILE: rtl/core/lssr_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module lssr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/core/lssr_ctrl.sv
// Controller state machine sequencing marker search, filtering and result hand-off.
`timescale 1ns / 1ps
module lssr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lssr_pkg::sts_t sts_i,
  output lssr_pkg::cmd_t cmd_o
);
  import lssr_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOP   = 3'd1;
  localparam logic [2:0] S_MCHK   = 3'd2;
  localparam logic [2:0] S_MCMP   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_SKIP   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.op_drain) state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts_i.loop_go) begin
          cmd_o.match_start = 1'b1;
          state_d = S_MCHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_MCHK: begin
        if (sts_i.m_end) begin
          state_d = S_DECIDE;
        end else if (sts_i.m_skip) begin
          cmd_o.m_next = 1'b1;
        end else begin
          cmd_o.k_start = 1'b1;
          state_d = S_MCMP;
        end
      end
      S_MCMP: begin
        if (!sts_i.k_eq) begin
          cmd_o.m_next = 1'b1;
          state_d = S_MCHK;
        end else if (sts_i.k_last) begin
          cmd_o.m_hit = 1'b1;
          state_d = S_MCHK;
        end else begin
          cmd_o.k_next = 1'b1;
        end
      end
      S_DECIDE: begin
        if (!sts_i.dec_stall) begin
          cmd_o.decide = 1'b1;
          state_d = S_SKIP;
        end
      end
      S_SKIP: begin
        cmd_o.shift = 1'b1;
        if (sts_i.skip_one) state_d = S_LOOP;
      end
      S_FIN: begin
        if (!sts_i.fin_need) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.match_start, cmd_o.m_next, cmd_o.m_hit, cmd_o.k_start,
              cmd_o.k_next, cmd_o.decide, cmd_o.shift, cmd_o.finish}))
    else $error("controller issued more than one command");
  a_cmp_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MCMP) |-> ($past(cmd_o.k_start) || $past(cmd_o.k_next)))
    else $error("compare state entered without a read in flight");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> (state_q == S_IDLE))
    else $error("request accepted outside idle");
endmodule

FILE: rtl/core/lssr_dp.sv
// Datapath: pending window, marker storage, search counters, filter and result registers.
`timescale 1ns / 1ps
module lssr_dp #(
  parameter int unsigned MAX_MARKERS    = 8,
  parameter int unsigned MAX_MARKER_LEN = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     operation_i,
  input  logic [7:0]     byte_value_i,
  input  logic           marker_end_i,
  input  lssr_pkg::cmd_t cmd_i,
  output lssr_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lssr_pkg::res_t out_res_o,
  output logic           out_last_o
);
  import lssr_pkg::*;

  localparam int unsigned PEND   = MAX_MARKER_LEN + 1;
  localparam int unsigned LW     = $clog2(MAX_MARKER_LEN + 1);
  localparam int unsigned CW     = $clog2(MAX_MARKER_LEN + 2);
  localparam int unsigned MW     = $clog2(MAX_MARKERS + 1);
  localparam int unsigned MIW    = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
  localparam int unsigned DEPTH  = MAX_MARKERS * MAX_MARKER_LEN;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned WAW    = $clog2(PEND);
  localparam int unsigned WDEPTH = 2 ** WAW;

  logic [7:0]    win_q [PEND];
  logic [LW-1:0] len_q [MAX_MARKERS];
  logic [CW-1:0] pcnt_q;
  logic [MW-1:0] cnt_q;
  logic [LW-1:0] span_q, load_len_q, best_q, k_q, skip_q;
  logic [MW-1:0] m_q;
  logic          ovf_q, esc_q, csi_q, fin_q, hold_v_q, out_v_q, out_last_q;
  logic [5:0]    n_q;
  logic [WAW-1:0] head_q;
  res_t          hold_q, out_q;

  op_e op;
  assign op = op_e'(operation_i);
  logic acc_data, acc_mark, acc_clear;
  assign acc_data  = cmd_i.accept && (op == OP_DATA);
  assign acc_mark  = cmd_i.accept && (op == OP_MARK);
  assign acc_clear = cmd_i.accept && (op == OP_CLEAR);

  // Marker loading.
  logic          ld_room, cnt_room;
  logic [LW-1:0] ld_next;
  logic          ovf_next;
  assign ld_room  = load_len_q < LW'(MAX_MARKER_LEN);
  assign cnt_room = cnt_q < MW'(MAX_MARKERS);
  assign ld_next  = ld_room ? load_len_q + 1'b1 : load_len_q;
  assign ovf_next = ovf_q || !ld_room;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;
  logic [LW-1:0] k_rd;
  assign ram_we    = acc_mark && ld_room && cnt_room;
  assign ram_waddr = AW'(cnt_q[MIW-1:0]) * AW'(MAX_MARKER_LEN) + AW'(load_len_q);
  assign k_rd      = cmd_i.k_start ? '0 : k_q + 1'b1;
  assign ram_raddr = AW'(m_q[MIW-1:0]) * AW'(MAX_MARKER_LEN) + AW'(k_rd);

  lssr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (byte_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A ring copy of the window is read alongside the marker RAM during a compare.
  logic           win_we;
  logic [WAW-1:0] win_waddr, win_raddr;
  logic [7:0]     win_rdata;
  assign win_we    = acc_data && pcnt_q < CW'(PEND);
  assign win_waddr = head_q + WAW'(pcnt_q);
  assign win_raddr = head_q + WAW'(k_rd);

  lssr_ram #(.WIDTH(8), .DEPTH(WDEPTH)) u_win_ram (
    .clk_i   (clk_i),
    .we_i    (win_we),
    .waddr_i (win_waddr),
    .wdata_i (byte_value_i),
    .raddr_i (win_raddr),
    .rdata_o (win_rdata)
  );

  // Marker search.
  logic [LW-1:0] cur_len;
  assign cur_len = len_q[m_q[MIW-1:0]];

  // Front byte filter.
  logic [7:0]  c, w1, w2, w3;
  logic [2:0]  ulen, f_cnt;
  logic        u_ok, f_emit, esc_d, csi_d;
  logic [31:0] f_text;
  assign c  = win_q[0];
  assign w1 = win_q[1];
  assign w2 = win_q[2];
  assign w3 = win_q[3];

  always_comb begin
    ulen = 3'd0;
    if (c inside {[8'hc2:8'hdf]}) ulen = 3'd2;
    else if (c inside {[8'he0:8'hef]}) ulen = 3'd3;
    else if (c inside {[8'hf0:8'hf4]}) ulen = 3'd4;
    u_ok = (ulen != 3'd0) && (CW'(ulen) <= pcnt_q) && (w1 inside {[8'h80:8'hbf]})
           && ((ulen < 3'd3) || (w2 inside {[8'h80:8'hbf]}))
           && ((ulen < 3'd4) || (w3 inside {[8'h80:8'hbf]}));
    if (ulen >= 3'd3) begin
      u_ok = u_ok && !(c == 8'he0 && w1 < 8'ha0) && !(c == 8'hed && w1 >= 8'ha0)
                  && !(c == 8'hf0 && w1 < 8'h90) && !(c == 8'hf4 && w1 >= 8'h90);
    end
    esc_d  = esc_q;
    csi_d  = csi_q;
    f_emit = 1'b0;
    f_cnt  = 3'd1;
    f_text = {24'd0, c};
    if (esc_q) begin
      if (c == CH_LBR) begin
        csi_d = 1'b1;
      end else if (!csi_q || (c inside {[8'h40:8'h7e]})) begin
        esc_d = 1'b0;
        csi_d = 1'b0;
      end
    end else if (c == CH_ESC) begin
      esc_d = 1'b1;
    end else if ((c < 8'h20 && c != CH_NL && c != CH_CR && c != CH_TAB) || c == CH_DEL) begin
      f_emit = 1'b0;
    end else if (c < 8'h80) begin
      f_emit = 1'b1;
    end else if (u_ok) begin
      f_emit = 1'b1;
      f_cnt  = ulen;
      f_text = {(ulen == 3'd4) ? w3 : 8'd0, (ulen >= 3'd3) ? w2 : 8'd0, w1, c};
    end else begin
      f_emit = 1'b1;
      f_text = {24'd0, CH_QM};
    end
  end

  logic  out_free, dec_emit;
  res_t  dec_res;
  assign out_free = !out_v_q || out_ready_i;
  assign dec_emit = (best_q != '0) || f_emit;
  assign dec_res  = (best_q != '0) ? res_t'{1'b1, 3'd0, 32'd0} : res_t'{1'b0, f_cnt, f_text};

  always_comb begin
    sts_o           = '0;
    sts_o.op_drain  = (op == OP_DATA) || (op == OP_FLUSH);
    sts_o.loop_go   = (pcnt_q != '0) && (fin_q || pcnt_q > CW'(span_q))
                      && (n_q < 6'(RESULT_CAP));
    sts_o.m_end     = (m_q >= cnt_q);
    sts_o.m_skip    = (cur_len == '0) || (CW'(cur_len) > pcnt_q) || (cur_len <= best_q);
    sts_o.k_eq      = fold_byte(win_rdata) == fold_byte(ram_rdata);
    sts_o.k_last    = (k_q + 1'b1) == cur_len;
    sts_o.dec_stall = hold_v_q && dec_emit && !out_free;
    sts_o.skip_one  = (skip_q == LW'(1));
    sts_o.fin_need  = hold_v_q || fin_q;
    sts_o.out_free  = out_free;
  end

  // Payload storage without reset.
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_q[pcnt_q[LW-1:0]] <= byte_value_i;
    end else if (cmd_i.shift) begin
      for (int i = 0; i < PEND - 1; i++) win_q[i] <= win_q[i + 1];
    end
    if (acc_mark && marker_end_i && !ovf_next && cnt_room && ld_next != '0) begin
      len_q[cnt_q[MIW-1:0]] <= ld_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q     <= '0;
      cnt_q      <= '0;
      span_q     <= LW'(4);
      load_len_q <= '0;
      ovf_q      <= 1'b0;
      esc_q      <= 1'b0;
      csi_q      <= 1'b0;
      fin_q      <= 1'b0;
      best_q     <= '0;
      m_q        <= '0;
      k_q        <= '0;
      skip_q     <= '0;
      n_q        <= '0;
      head_q     <= '0;
      hold_v_q   <= 1'b0;
      hold_q     <= '0;
      out_v_q    <= 1'b0;
      out_q      <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;

      if (cmd_i.accept) begin
        fin_q <= (op == OP_FLUSH);
        n_q   <= '0;
      end
      if (win_we) pcnt_q <= pcnt_q + 1'b1;
      if (acc_mark) begin
        if (marker_end_i) begin
          if (!ovf_next && cnt_room && ld_next != '0) begin
            cnt_q <= cnt_q + 1'b1;
            if (ld_next > span_q) span_q <= ld_next;
          end
          load_len_q <= '0;
          ovf_q      <= 1'b0;
        end else begin
          load_len_q <= ld_next;
          ovf_q      <= ovf_next;
        end
      end
      if (acc_clear) begin
        cnt_q      <= '0;
        span_q     <= LW'(4);
        load_len_q <= '0;
        ovf_q      <= 1'b0;
      end

      if (cmd_i.match_start) begin
        m_q    <= '0;
        best_q <= '0;
      end
      if (cmd_i.m_next) m_q <= m_q + 1'b1;
      if (cmd_i.m_hit) begin
        m_q    <= m_q + 1'b1;
        best_q <= cur_len;
      end
      if (cmd_i.k_start) k_q <= '0;
      if (cmd_i.k_next) k_q <= k_q + 1'b1;

      if (cmd_i.decide) begin
        if (best_q != '0) begin
          skip_q <= best_q;
        end else begin
          skip_q <= LW'(f_cnt);
          esc_q  <= esc_d;
          csi_q  <= csi_d;
        end
        if (dec_emit) begin
          // The previous result is only known not to be the final one now.
          if (hold_v_q) begin
            out_v_q    <= 1'b1;
            out_q      <= hold_q;
            out_last_q <= 1'b0;
          end
          hold_q   <= dec_res;
          hold_v_q <= 1'b1;
          n_q      <= n_q + 1'b1;
        end
      end
      if (cmd_i.shift) begin
        pcnt_q <= pcnt_q - 1'b1;
        skip_q <= skip_q - 1'b1;
        head_q <= head_q + 1'b1;
      end
      if (cmd_i.finish) begin
        out_v_q    <= 1'b1;
        out_last_q <= fin_q;
        out_q      <= hold_v_q ? hold_q : res_t'{1'b0, 3'd0, 32'd0};
        hold_v_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q <= CW'(PEND))
    else $error("pending window overfilled");
  a_span_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_q >= LW'(4) && span_q <= LW'(MAX_MARKER_LEN))
    else $error("window span out of range");
  a_token_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.kind) |-> (out_q.byte_count == 3'd0 && out_q.text_bytes == 32'd0))
    else $error("redaction token carries text");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MW'(MAX_MARKERS))
    else $error("marker count exceeds capacity");
endmodule

FILE: rtl/core/log_stream_sanitizer_redactor_core.sv
// Top level of the log stream sanitiser and redactor.
`timescale 1ns / 1ps
// Each request carries a data byte, a marker byte, a flush or a clear. Marker bytes
// and clears give no result. A data byte or a flush walks the pending window: for
// every examined front position the controller scans the loaded markers one after
// another, comparing a candidate marker byte by byte (the marker RAM gives one byte
// a cycle), then decides and shifts the window once per consumed byte. Results leave
// through a registered output stage; the result before the last is released when
// the next one is made, so the final result of a flush can carry last. The block
// holds the input ready low while it works and needs no clearing pass after reset.
module log_stream_sanitizer_redactor_core #(
  parameter int unsigned MAX_MARKERS    = 8,
  parameter int unsigned MAX_MARKER_LEN = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  lssr_in_if.sink    in_i,
  lssr_out_if.source out_o
);
  import lssr_pkg::*;

  cmd_t cmd;
  sts_t sts;
  res_t out_res;
  logic in_ready;

  lssr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lssr_dp #(
    .MAX_MARKERS    (MAX_MARKERS),
    .MAX_MARKER_LEN (MAX_MARKER_LEN)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .operation_i  (in_i.operation),
    .byte_value_i (in_i.byte_value),
    .marker_end_i (in_i.marker_end),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_res_o    (out_res),
    .out_last_o   (out_o.last)
  );

  assign in_i.ready       = in_ready;
  assign out_o.kind       = out_res.kind;
  assign out_o.byte_count = out_res.byte_count;
  assign out_o.text_bytes = out_res.text_bytes;
endmodule

FILE: bench/log_stream_sanitizer_redactor_core_tb.sv
// Self-checking testbench of the log stream sanitiser and redactor core.
`timescale 1ns / 1ps
module log_stream_sanitizer_redactor_core_tb;
  import lssr_pkg::*;

  localparam int unsigned NUM_MARKERS = 8;
  localparam int unsigned MARKER_LEN  = 32;
  localparam int unsigned MAX_OUT     = 32;
  localparam int unsigned IDLE_LIMIT  = 40000;
  localparam int unsigned RANDOM_REQS = 280;

  typedef struct {
    bit        kind;
    bit [2:0]  count;
    bit [31:0] text;
    bit        last;
  } chunk_t;

  logic clk;
  logic rst_n;

  lssr_in_if  in_if ();
  lssr_out_if out_if ();

  log_stream_sanitizer_redactor_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the sanitiser state.
  logic [7:0] mark_bytes [NUM_MARKERS][MARKER_LEN];
  int         mark_len [NUM_MARKERS];
  int         mark_count;
  int         span;
  int         load_len;
  bit         load_over;
  logic [7:0] window_q [$];
  bit         esc_on;
  bit         csi_on;

  chunk_t     chunk_q [$];
  string      marker_texts [$];
  int         errors;
  int         idle_cycles;
  int         sent;
  bit         quiet;
  int         hold_cnt;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [7:0] fold(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) return c + 8'h20;
    if (c == CH_BSL) return CH_SL;
    return c;
  endfunction

  function automatic int longest_hit(int pos);
    int best;
    bit ok;
    best = 0;
    for (int m = 0; m < mark_count; m++) begin
      if (mark_len[m] == 0 || mark_len[m] > window_q.size() - pos || mark_len[m] <= best)
        continue;
      ok = 1'b1;
      for (int k = 0; k < mark_len[m] && ok; k++)
        ok = fold(window_q[pos + k]) == fold(mark_bytes[m][k]);
      if (ok) best = mark_len[m];
    end
    return best;
  endfunction

  function automatic void push_chunk(bit kind, bit [2:0] count, bit [31:0] text);
    chunk_t r;
    r.kind  = kind;
    r.count = count;
    r.text  = text;
    r.last  = 1'b0;
    chunk_q = {chunk_q, r};
  endfunction

  // Walks the window and queues the text and tokens that leave it.
  function automatic int sanitise_window(bit draining);
    int i, n, len, cnt;
    logic [7:0] c, nx;
    bit ok;
    bit [31:0] text;
    i = 0;
    n = 0;
    while (i < window_q.size() && (draining || window_q.size() - i > span) && n < MAX_OUT) begin
      len = longest_hit(i);
      if (len != 0) begin
        push_chunk(1'b1, 3'd0, 32'd0);
        n++;
        i += len;
        continue;
      end
      c = window_q[i];
      i++;
      if (esc_on) begin
        if (c == CH_LBR) begin
          csi_on = 1'b1;
        end else if (!csi_on || (c >= 8'h40 && c <= 8'h7e)) begin
          esc_on = 1'b0;
          csi_on = 1'b0;
        end
        continue;
      end
      if (c == CH_ESC) begin
        esc_on = 1'b1;
        continue;
      end
      if ((c < 8'd32 && c != CH_NL && c != CH_CR && c != CH_TAB) || c == CH_DEL) continue;
      if (c < 8'd128) begin
        push_chunk(1'b0, 3'd1, {24'd0, c});
        n++;
        continue;
      end
      cnt = (c >= 8'hc2 && c <= 8'hdf) ? 2 : (c >= 8'he0 && c <= 8'hef) ? 3 :
            (c >= 8'hf0 && c <= 8'hf4) ? 4 : 0;
      ok = cnt != 0 && i - 1 + cnt <= window_q.size();
      for (int j = 1; ok && j < cnt; j++) begin
        nx = window_q[i - 1 + j];
        ok = nx >= 8'h80 && nx <= 8'hbf;
      end
      if (ok && cnt >= 3) begin
        nx = window_q[i];
        ok = !(c == 8'he0 && nx < 8'ha0) && !(c == 8'hed && nx >= 8'ha0) &&
             !(c == 8'hf0 && nx < 8'h90) && !(c == 8'hf4 && nx >= 8'h90);
      end
      if (ok) begin
        text = '0;
        for (int j = 0; j < cnt; j++) text |= 32'(window_q[i - 1 + j]) << (8 * j);
        push_chunk(1'b0, 3'(cnt), text);
        i += cnt - 1;
      end else begin
        push_chunk(1'b0, 3'd1, {24'd0, CH_QM});
      end
      n++;
    end
    if (i > window_q.size()) i = window_q.size();
    repeat (i) void'(window_q.pop_front());
    return n;
  endfunction

  function automatic void predict(op_e op, logic [7:0] b, bit e);
    int n;
    case (op)
      OP_DATA: begin
        if (window_q.size() < MARKER_LEN + 1) window_q = {window_q, b};
        void'(sanitise_window(1'b0));
      end
      OP_MARK: begin
        if (load_len < MARKER_LEN) begin
          if (mark_count < NUM_MARKERS) mark_bytes[mark_count][load_len] = b;
          load_len++;
        end else begin
          load_over = 1'b1;
        end
        if (e) begin
          if (!load_over && mark_count < NUM_MARKERS && load_len > 0) begin
            mark_len[mark_count] = load_len;
            mark_count++;
            if (load_len > span) span = load_len;
          end
          load_len  = 0;
          load_over = 1'b0;
        end
      end
      OP_FLUSH: begin
        n = sanitise_window(1'b1);
        if (n == 0) push_chunk(1'b0, 3'd0, 32'd0);
        chunk_q[chunk_q.size() - 1].last = 1'b1;
      end
      default: begin
        mark_count = 0;
        span       = 4;
        load_len   = 0;
        load_over  = 1'b0;
      end
    endcase
  endfunction

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic send(op_e op, logic [7:0] b, bit e = 1'b0);
    int r, gap;
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.byte_value <= b;
    in_if.marker_end <= e;
    do @(posedge clk); while (!in_if.ready);
    predict(op, b, e);
    sent++;
    r = $urandom_range(0, 99);
    gap = quiet ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(string s);
    for (int k = 0; k < s.len(); k++) send(OP_DATA, s[k]);
  endtask

  task automatic load_marker(string s);
    for (int k = 0; k < s.len(); k++) send(OP_MARK, s[k], k == s.len() - 1);
    marker_texts = {marker_texts, s};
  endtask

  // The request line is dropped first so that the last request is not taken twice.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (chunk_q.size() != 0) @(posedge clk);
  endtask

  function automatic string random_marker(int len);
    string s, pool;
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789/\\=:";
    s = "";
    for (int k = 0; k < len; k++) s = {s, pool.substr(0, 0)};
    for (int k = 0; k < len; k++) s[k] = pool[$urandom_range(0, pool.len() - 1)];
    return s;
  endfunction

  // Sink side: random back-pressure, with calm stretches.
  always @(posedge clk or negedge rst_n) begin
    int r;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (quiet) begin
        out_if.ready <= 1'b1;
      end else if (r < 60) begin
        out_if.ready <= 1'b1;
        hold_cnt     <= $urandom_range(0, 3);
      end else if (r < 95) begin
        out_if.ready <= 1'b0;
        hold_cnt     <= $urandom_range(0, 3);
      end else begin
        out_if.ready <= 1'b0;
        hold_cnt     <= $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk) begin
    chunk_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (chunk_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d text %h", out_if.kind, out_if.text_bytes));
      end else begin
        e = chunk_q.pop_front();
        if (out_if.kind !== e.kind)
          report($sformatf("kind %0d, expected %0d", out_if.kind, e.kind));
        if (out_if.byte_count !== e.count)
          report($sformatf("byte_count %0d, expected %0d", out_if.byte_count, e.count));
        if (out_if.text_bytes !== e.text)
          report($sformatf("text_bytes %h, expected %h", out_if.text_bytes, e.text));
        if (out_if.last !== e.last)
          report($sformatf("last %0d, expected %0d", out_if.last, e.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_plain_text();
    send_text("Az~");
    send(OP_DATA, 8'h00);
    send(OP_DATA, CH_DEL);
    send(OP_DATA, CH_TAB);
    send(OP_DATA, CH_NL);
    send(OP_DATA, CH_CR);
    send(OP_DATA, 8'h1f);
    send(OP_FLUSH, 8'h00);
    // A second flush has nothing left to drain.
    send(OP_FLUSH, 8'hff);
  endtask

  task automatic test_escapes_and_utf8();
    send(OP_DATA, CH_ESC); send(OP_DATA, 8'h63);
    send(OP_DATA, CH_ESC); send_text("[1;3"); send(OP_DATA, 8'h7e);
    send(OP_DATA, 8'hc3); send(OP_DATA, 8'ha9);
    send(OP_DATA, 8'he0); send(OP_DATA, 8'h80); send(OP_DATA, 8'h80);
    send(OP_DATA, 8'hed); send(OP_DATA, 8'ha0); send(OP_DATA, 8'h80);
    send(OP_DATA, 8'hf4); send(OP_DATA, 8'h90); send(OP_DATA, 8'h80); send(OP_DATA, 8'h80);
    send(OP_DATA, 8'hf0); send(OP_DATA, 8'h9f); send(OP_DATA, 8'h98); send(OP_DATA, 8'h80);
    send(OP_DATA, 8'hc0); send(OP_DATA, 8'hff);
    // An escape left open and a truncated sequence meet the flush.
    send(OP_DATA, 8'hf0); send(OP_DATA, 8'h9f); send(OP_DATA, CH_ESC);
    send(OP_FLUSH, 8'h00);
    send(OP_DATA, 8'h41);
    send(OP_FLUSH, 8'h00);
  endtask

  task automatic test_markers();
    load_marker("ab");
    load_marker("abc");
    load_marker("a/b");
    load_marker("A\\B");
    load_marker("pass");
    send_text("xABCx a\\b A/B PaSs");
    send(OP_FLUSH, 8'h00);
    // The over-long marker and the one beyond the marker capacity are refused.
    load_marker(random_marker(MARKER_LEN));
    load_marker(random_marker(MARKER_LEN + 2));
    load_marker("ghi");
    load_marker("jkl");
    load_marker("mno");
    send_text({"jkl", marker_texts[5], "zz"});
    send(OP_FLUSH, 8'h00);
    wait_for_results();
  endtask

  task automatic send_random_chunk();
    int r, n;
    string s;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) send(OP_DATA, 8'($urandom_range(32, 126)));
    end else if (r < 48) begin
      if (marker_texts.size() == 0) return;
      s = marker_texts[$urandom_range(0, marker_texts.size() - 1)];
      for (int k = 0; k < s.len(); k++) begin
        if ($urandom_range(0, 1) && ((s[k] | 8'h20) >= "a") && ((s[k] | 8'h20) <= "z"))
          s[k] = s[k] ^ 8'h20;
        else if ($urandom_range(0, 1) && (s[k] == "/" || s[k] == "\\"))
          s[k] = (s[k] == "/") ? "\\" : "/";
      end
      if ($urandom_range(0, 3) == 0) s[$urandom_range(0, s.len() - 1)] = "#";
      send_text(s);
    end else if (r < 56) begin
      send(OP_DATA, CH_ESC);
      if ($urandom_range(0, 1)) begin
        send(OP_DATA, CH_LBR);
        n = $urandom_range(0, 4);
        for (int k = 0; k < n; k++) send(OP_DATA, 8'($urandom_range(32, 63)));
      end
      send(OP_DATA, 8'($urandom_range(0, 255)));
    end else if (r < 66) begin
      n = $urandom_range(2, 4);
      case (n)
        2: send(OP_DATA, 8'($urandom_range(8'hc2, 8'hdf)));
        3: send(OP_DATA, 8'($urandom_range(8'he1, 8'hec)));
        default: send(OP_DATA, 8'($urandom_range(8'hf1, 8'hf3)));
      endcase
      for (int k = 1; k < n; k++) send(OP_DATA, 8'($urandom_range(8'h80, 8'hbf)));
    end else if (r < 76) begin
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) send(OP_DATA, 8'($urandom_range(0, 255)));
    end else if (r < 82) begin
      send(OP_DATA, 8'($urandom_range(0, 31)));
    end else if (r < 90) begin
      send(OP_FLUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else if (r < 98) begin
      n = $urandom_range(0, 9) == 0 ? $urandom_range(MARKER_LEN - 1, MARKER_LEN + 2)
                                     : $urandom_range(1, 7);
      load_marker(random_marker(n));
    end else begin
      send(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      marker_texts.delete();
    end
  endtask

  task automatic test_random_traffic();
    int start;
    start = sent;
    while (sent - start < RANDOM_REQS) begin
      quiet = ((sent - start) % 150) < 25;
      send_random_chunk();
    end
    quiet = 1'b0;
  endtask

  initial begin
    errors       = 0;
    sent         = 0;
    quiet        = 1'b0;
    mark_count   = 0;
    span         = 4;
    load_len     = 0;
    load_over    = 1'b0;
    esc_on       = 1'b0;
    csi_on       = 1'b0;
    rst_n        = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.operation  <= OP_DATA;
    in_if.byte_value <= 8'h00;
    in_if.marker_end <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_text();
    test_escapes_and_utf8();
    wait_for_results();
    test_markers();
    test_random_traffic();

    send(OP_FLUSH, 8'h00);
    wait_for_results();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
